/* rtl/idheap_pkg.sv */
// Shared types, sizes and codes for the indexed d-ary min-heap.
`default_nettype none
package idheap_pkg;

    // Sizes
    localparam int NODES     = 1024;
    localparam int ID_W      = 10;
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int KEY_W     = 32;
    localparam int ARITY_W   = 4;
    localparam int MIN_ARITY = 2;
    localparam int MAX_ARITY = 8;
    // d * slot + 1 + d fits here
    localparam int CHILD_W   = 14;

    // Operation codes
    localparam logic [1:0] FUNC_INSERT   = 2'd0;
    localparam logic [1:0] FUNC_REMOVE   = 2'd1;
    localparam logic [1:0] FUNC_DECREASE = 2'd2;
    localparam logic [1:0] FUNC_PEEK     = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [ID_W-1:0]  node_id;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]  out_node;
        logic [KEY_W-1:0] out_key;
        logic [1:0]       status;
    } t_out_word;

endpackage
`default_nettype wire

/* rtl/idheap_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module idheap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/indexed_d_ary_min_heap.sv */
// Top level of the indexed d-ary min-heap priority queue with its sequencer.
`default_nettype none
// Indexed d-ary min-heap of up to 1024 node ids keyed by 32-bit distance, with
// insert, remove-min, decrease-key and peek-min. One word is processed at a
// time; o_in_stall stays high until its result has been loaded into the output
// register. After reset the block writes the identity permutation into its slot
// and position memories before it takes a word. Each heap level costs one memory
// read per visited slot: sift-up finds the parent with a 10-step shared restoring
// divider, then does one read and one compare; sift-down does one read and
// compare per child, plus setup, loop exit and the move.
// Arity is written through i_cfg_we/i_cfg_wdata; the user must write it only
// while idle, not enforced by the block. Values below 2 act as 2, above 8 as 8.
module indexed_d_ary_min_heap (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [3:0]            i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire idheap_pkg::t_in_word  i_in_word,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      idheap_pkg::t_out_word o_out_word
);
    import idheap_pkg::*;

    typedef enum logic [15:0] {
        S_CLEAR    = 16'h0001,
        S_IDLE     = 16'h0002,
        S_NS_WAIT  = 16'h0004,
        S_INS_RD   = 16'h0008,
        S_UP_CHK   = 16'h0010,
        S_DIV      = 16'h0020,
        S_UP_RD    = 16'h0040,
        S_UP_CMP   = 16'h0080,
        S_ROOT     = 16'h0100,
        S_RM_RD    = 16'h0200,
        S_DN_START = 16'h0400,
        S_DN_LOOP  = 16'h0800,
        S_DN_CMP   = 16'h1000,
        S_DN_END   = 16'h2000,
        S_FIN      = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    localparam int SM_W = ID_W + KEY_W;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ARITY_W-1:0]  r_arity;
    logic [ARITY_W-1:0]  r_d, n_d;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [1:0]          r_func, n_func;
    logic [ID_W-1:0]     r_id, n_id;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SLOT_W-1:0]   r_s, n_s;
    logic [ID_W-1:0]     r_mnode, n_mnode;
    logic [KEY_W-1:0]    r_mkey, n_mkey;
    logic [ID_W-1:0]     r_res_node, n_res_node;
    logic [KEY_W-1:0]    r_res_key, n_res_key;
    logic [1:0]          r_status, n_status;
    logic [CHILD_W-1:0]  r_c, n_c;
    logic [CHILD_W-1:0]  r_cend, n_cend;
    logic [SLOT_W-1:0]   r_best, n_best;
    logic [ID_W-1:0]     r_bnode, n_bnode;
    logic [KEY_W-1:0]    r_bkey, n_bkey;
    logic                r_moved, n_moved;
    logic [SLOT_W-1:0]   r_dq, n_dq;
    logic [ARITY_W-1:0]  r_rem, n_rem;
    logic [3:0]          r_dcnt, n_dcnt;
    logic                r_ovalid, n_ovalid;
    t_out_word           r_out, n_out;

    // Memory ports
    logic                sm_we, nm_we;
    logic [SLOT_W-1:0]   sm_waddr, sm_raddr;
    logic [SM_W-1:0]     sm_wdata, sm_rdata;
    logic [SLOT_W-1:0]   nm_waddr, nm_raddr;
    logic [SLOT_W-1:0]   nm_wdata, nm_rdata;
    logic [ID_W-1:0]     sm_rnode;
    logic [KEY_W-1:0]    sm_rkey;

    logic [ARITY_W-1:0]  eff_arity;
    logic                in_acc;
    logic [ARITY_W:0]    rem_sh;
    logic [CHILD_W-1:0]  first;

    // Slot store: {node, key} per slot; position store: slot per node
    idheap_ram #(.WIDTH(SM_W), .DEPTH(NODES)) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    idheap_ram #(.WIDTH(SLOT_W), .DEPTH(NODES)) u_pos_mem (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_raddr (nm_raddr),
        .o_rdata (nm_rdata)
    );

    assign sm_rnode = sm_rdata[KEY_W +: ID_W];
    assign sm_rkey  = sm_rdata[KEY_W-1:0];

    // Clamp arity to the supported range
    always_comb begin
        priority if (r_arity < ARITY_W'(MIN_ARITY)) begin
            eff_arity = ARITY_W'(MIN_ARITY);
        end else if (r_arity > ARITY_W'(MAX_ARITY)) begin
            eff_arity = ARITY_W'(MAX_ARITY);
        end else begin
            eff_arity = r_arity;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    // Shared divider step and first-child address
    assign rem_sh = {r_rem, r_dq[SLOT_W-1]};
    assign first  = CHILD_W'(r_d) * CHILD_W'(r_s) + CHILD_W'(1);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_d        = r_d;
        n_clr      = r_clr;
        n_func     = r_func;
        n_id       = r_id;
        n_key      = r_key;
        n_s        = r_s;
        n_mnode    = r_mnode;
        n_mkey     = r_mkey;
        n_res_node = r_res_node;
        n_res_key  = r_res_key;
        n_status   = r_status;
        n_c        = r_c;
        n_cend     = r_cend;
        n_best     = r_best;
        n_bnode    = r_bnode;
        n_bkey     = r_bkey;
        n_moved    = r_moved;
        n_dq       = r_dq;
        n_rem      = r_rem;
        n_dcnt     = r_dcnt;
        n_out      = r_out;
        n_ovalid   = r_ovalid && i_out_stall;
        sm_we      = 1'b0;
        sm_waddr   = '0;
        sm_wdata   = '0;
        sm_raddr   = '0;
        nm_we      = 1'b0;
        nm_waddr   = '0;
        nm_wdata   = '0;
        nm_raddr   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // identity permutation, one slot a cycle
                sm_we    = 1'b1;
                sm_waddr = r_clr;
                sm_wdata = {ID_W'(r_clr), KEY_W'(0)};
                nm_we    = 1'b1;
                nm_waddr = r_clr;
                nm_wdata = r_clr;
                n_clr    = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_func     = i_in_word.func;
                    n_id       = i_in_word.node_id;
                    n_key      = i_in_word.key;
                    n_d        = eff_arity;
                    n_res_node = '0;
                    n_res_key  = '0;
                    n_status   = ST_OK;
                    if (i_in_word.func == FUNC_INSERT || i_in_word.func == FUNC_DECREASE) begin
                        if ({1'b0, i_in_word.node_id} >= (ID_W+1)'(NODES)) begin
                            n_status = ST_ABSENT;
                            n_state  = S_DONE;
                        end else begin
                            nm_raddr = SLOT_W'(i_in_word.node_id);
                            n_state  = S_NS_WAIT;
                        end
                    end else if (r_cnt == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        sm_raddr = '0;
                        n_state  = S_ROOT;
                    end
                end
            end
            S_NS_WAIT: begin
                if (r_func == FUNC_INSERT) begin
                    if (CNT_W'(nm_rdata) < r_cnt) begin
                        n_status = ST_DUP;
                        n_state  = S_DONE;
                    end else begin
                        sm_raddr = r_cnt[SLOT_W-1:0];
                        n_s      = nm_rdata;
                        n_state  = S_INS_RD;
                    end
                end else if (CNT_W'(nm_rdata) >= r_cnt) begin
                    n_status = ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    n_s     = nm_rdata;
                    n_mnode = r_id;
                    n_mkey  = r_key;
                    n_state = S_UP_CHK;
                end
            end
            S_INS_RD: begin
                // node at the heap end moves to the inserted node's old slot
                sm_we    = 1'b1;
                sm_waddr = r_s;
                sm_wdata = sm_rdata;
                nm_we    = 1'b1;
                nm_waddr = SLOT_W'(sm_rnode);
                nm_wdata = r_s;
                n_s      = r_cnt[SLOT_W-1:0];
                n_cnt    = r_cnt + CNT_W'(1);
                n_mnode  = r_id;
                n_mkey   = r_key;
                n_state  = S_UP_CHK;
            end
            S_UP_CHK: begin
                if (r_s == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_dq    = r_s - SLOT_W'(1);
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit a cycle
                if (rem_sh >= {1'b0, r_d}) begin
                    n_rem = ARITY_W'(rem_sh - {1'b0, r_d});
                    n_dq  = {r_dq[SLOT_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[ARITY_W-1:0];
                    n_dq  = {r_dq[SLOT_W-2:0], 1'b0};
                end
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'(SLOT_W - 1)) begin
                    n_state = S_UP_RD;
                end
            end
            S_UP_RD: begin
                sm_raddr = r_dq;
                n_state  = S_UP_CMP;
            end
            S_UP_CMP: begin
                // parent strictly greater: it drops into the hole
                if (sm_rkey > r_mkey) begin
                    sm_we    = 1'b1;
                    sm_waddr = r_s;
                    sm_wdata = sm_rdata;
                    nm_we    = 1'b1;
                    nm_waddr = SLOT_W'(sm_rnode);
                    nm_wdata = r_s;
                    n_s      = r_dq;
                    n_state  = S_UP_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ROOT: begin
                n_res_node = sm_rnode;
                n_res_key  = sm_rkey;
                if (r_func == FUNC_PEEK) begin
                    n_state = S_DONE;
                end else begin
                    sm_raddr = SLOT_W'(r_cnt - CNT_W'(1));
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_state  = S_RM_RD;
                end
            end
            S_RM_RD: begin
                // removed root goes to the old last slot; last entry sifts down
                sm_we    = 1'b1;
                sm_waddr = r_cnt[SLOT_W-1:0];
                sm_wdata = {r_res_node, r_res_key};
                nm_we    = 1'b1;
                nm_waddr = SLOT_W'(r_res_node);
                nm_wdata = r_cnt[SLOT_W-1:0];
                n_mnode  = sm_rnode;
                n_mkey   = sm_rkey;
                n_s      = '0;
                n_state  = S_DN_START;
            end
            S_DN_START: begin
                n_c     = first;
                n_cend  = first + CHILD_W'(r_d);
                n_best  = r_s;
                n_bkey  = r_mkey;
                n_bnode = r_mnode;
                n_moved = 1'b0;
                n_state = S_DN_LOOP;
            end
            S_DN_LOOP: begin
                if (r_c < r_cend && r_c < CHILD_W'(r_cnt)) begin
                    sm_raddr = r_c[SLOT_W-1:0];
                    n_state  = S_DN_CMP;
                end else begin
                    n_state = S_DN_END;
                end
            end
            S_DN_CMP: begin
                // smallest child below the moving key wins; on a tie the earlier child stays
                if (sm_rkey < r_bkey) begin
                    n_best  = r_c[SLOT_W-1:0];
                    n_bkey  = sm_rkey;
                    n_bnode = sm_rnode;
                    n_moved = 1'b1;
                end
                n_c     = r_c + CHILD_W'(1);
                n_state = S_DN_LOOP;
            end
            S_DN_END: begin
                if (r_moved) begin
                    sm_we    = 1'b1;
                    sm_waddr = r_s;
                    sm_wdata = {r_bnode, r_bkey};
                    nm_we    = 1'b1;
                    nm_waddr = SLOT_W'(r_bnode);
                    nm_wdata = r_s;
                    n_s      = r_best;
                    n_state  = S_DN_START;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // moving entry lands in the hole
                sm_we    = 1'b1;
                sm_waddr = r_s;
                sm_wdata = {r_mnode, r_mkey};
                nm_we    = 1'b1;
                nm_waddr = SLOT_W'(r_mnode);
                nm_wdata = r_s;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out.out_node = r_res_node;
                    n_out.out_key  = r_res_key;
                    n_out.status   = r_status;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_arity  <= ARITY_W'(MIN_ARITY);
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_arity <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_d        <= n_d;
        r_func     <= n_func;
        r_id       <= n_id;
        r_key      <= n_key;
        r_s        <= n_s;
        r_mnode    <= n_mnode;
        r_mkey     <= n_mkey;
        r_res_node <= n_res_node;
        r_res_key  <= n_res_key;
        r_status   <= n_status;
        r_c        <= n_c;
        r_cend     <= n_cend;
        r_best     <= n_best;
        r_bnode    <= n_bnode;
        r_bkey     <= n_bkey;
        r_moved    <= n_moved;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_out      <= n_out;
    end

`ifndef SYNTH
    // heap never holds more nodes than exist
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NODES))
        else $error("heap count out of range");

    // memories stay untouched while waiting for a word
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!sm_we && !nm_we))
        else $error("memory write while idle");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_d))
        else $error("divider remainder out of range");

    // an accepted word produces exactly one result before the next is taken
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || !i_out_stall)) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented");
`endif

endmodule
`default_nettype wire
